// ===== hdl/dwmf_pkg.sv =====
// Shared types and constants for the depth window median filter.
// Holds the item structs, the register index codes and the register reset values.
// No dependencies.
`timescale 1ns / 1ps

package dwmf_pkg;

    localparam int DEPTH_W        = 16;
    localparam int FRAME_WIDTH_W  = 10;
    localparam int FRAME_HEIGHT_W = 12;
    localparam int COL_W          = 9;
    localparam int ROW_W          = 12;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIMIT    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LIMIT   = 8'd3;

    // Register values after reset.
    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 10'd320;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd240;
    localparam logic [DEPTH_W-1:0]        LOW_LIMIT_RST    = 16'd10;
    localparam logic [DEPTH_W-1:0]        HIGH_LIMIT_RST   = 16'd2000;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_sample;
        logic               frame_start;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]   center_col;
        logic [ROW_W-1:0]   center_row;
        logic [DEPTH_W-1:0] median_depth;
        logic               window_ok;
    } out_item_t;

endpackage

// ===== hdl/dwmf_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the line stores of the depth window median filter. No dependencies.
`timescale 1ns / 1ps

module dwmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/depth_window_median_filter_top.sv =====
// Depth window median filter: an accepted item passes stage 1, stage 2 and the output register.
// Throughput is one item per cycle unless m_ready holds the output; it is set by one read of every
// line store bank and one write of the current row's bank per item, plus a rank-select median.
// Reset (aresetn low at a clock edge) clears the pipeline valids and the counters and
// loads the register defaults; the line stores and window registers are not cleared.
// Depends on dwmf_pkg and dwmf_ram.
`timescale 1ns / 1ps

module depth_window_median_filter_top #(
    parameter int WINDOW_SIDE = 3,
    parameter int MAX_WIDTH   = 512
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  dwmf_pkg::in_item_t                   s_data,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output dwmf_pkg::out_item_t                  m_data,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dwmf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dwmf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import dwmf_pkg::*;

    // Column counter width, the width used for width clamping, bank index width,
    // window size and the rank that marks the median.
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int EW         = (CW + 1 > FRAME_WIDTH_W) ? CW + 1 : FRAME_WIDTH_W;
    localparam int MW         = $clog2(WINDOW_SIDE);
    localparam int N          = WINDOW_SIDE * WINDOW_SIDE;
    localparam int MID        = (WINDOW_SIDE - 1) / 2;
    localparam int MED_RANK   = (N - 1) / 2;
    localparam int RKW        = $clog2(N);
    localparam int CENTER_OFS = WINDOW_SIDE - 1 - MID;

    localparam logic [EW-1:0]    W_MIN = EW'(WINDOW_SIDE);
    localparam logic [EW-1:0]    W_MAX = EW'(MAX_WIDTH);
    localparam logic [ROW_W-1:0] H_MIN = ROW_W'(WINDOW_SIDE);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ------------------------------------------------------------------
    logic [FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [DEPTH_W-1:0]        low_limit_reg;
    logic [DEPTH_W-1:0]        high_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            low_limit_reg    <= LOW_LIMIT_RST;
            high_limit_reg   <= HIGH_LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_data[FRAME_WIDTH_W-1:0];
                end
                REG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_data[FRAME_HEIGHT_W-1:0];
                end
                REG_LOW_LIMIT: begin
                    low_limit_reg <= cfg_data;
                end
                REG_HIGH_LIMIT: begin
                    high_limit_reg <= cfg_data;
                end
                default: begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when the
    // stage after it moves, so bubbles collapse and the input side keeps
    // taking items while a finished result waits on the output, until stages 1 and 2 are full.
    // ------------------------------------------------------------------
    logic m_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_adv;
    logic s2_adv;
    logic s1_adv;
    logic s_accept;
    logic s1_xfer;

    assign out_adv  = !m_valid_reg || m_ready;
    assign s2_adv   = !s2_valid_reg || out_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign s_ready  = s1_adv;
    assign s_accept = s_valid && s1_adv;
    assign s1_xfer  = s1_valid_reg && s2_adv;

    // ------------------------------------------------------------------
    // Stage 0: position counters, sample qualification, line store access.
    // bank_reg tracks the row number modulo the window side, which selects
    // the line store bank that the current row writes.
    // ------------------------------------------------------------------
    logic [CW-1:0]    col_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic [MW-1:0]    bank_reg;

    logic [CW-1:0]    col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [MW-1:0]    bank_cur;
    logic             sample_ok;
    logic [DEPTH_W-1:0] sample_w;
    logic             produce;
    logic [COL_W-1:0] center_col;
    logic [ROW_W-1:0] center_row;
    logic [EW-1:0]    fw_ext;
    logic [EW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [EW-1:0]    col_inc;
    logic [ROW_W:0]   row_inc;
    logic [CW-1:0]    col_count_next;
    logic [ROW_W-1:0] row_count_next;
    logic [MW-1:0]    bank_next;

    always_comb begin
        col_cur  = s_data.frame_start ? '0 : col_count_reg;
        row_cur  = s_data.frame_start ? '0 : row_count_reg;
        bank_cur = s_data.frame_start ? '0 : bank_reg;

        // A sample is valid strictly inside the limits; an invalid one is
        // stored as zero, and since a valid sample always exceeds the low
        // limit, a stored zero marks an invalid sample.
        sample_ok = (s_data.depth_sample > low_limit_reg) &&
                    (s_data.depth_sample < high_limit_reg);
        sample_w  = sample_ok ? s_data.depth_sample : '0;

        produce    = (col_cur >= CW'(WINDOW_SIDE - 1)) &&
                     (row_cur >= ROW_W'(WINDOW_SIDE - 1));
        center_col = COL_W'(col_cur - CW'(CENTER_OFS));
        center_row = row_cur - ROW_W'(CENTER_OFS);

        // Effective frame size: width clamped to the supported range,
        // height raised to at least one window.
        fw_ext = EW'(frame_width_reg);
        if (fw_ext < W_MIN) begin
            w_eff = W_MIN;
        end else if (fw_ext > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = fw_ext;
        end
        h_eff = (frame_height_reg < H_MIN) ? H_MIN : frame_height_reg;

        col_inc = EW'(col_cur) + EW'(1);
        row_inc = {1'b0, row_cur} + {{ROW_W{1'b0}}, 1'b1};

        if (col_inc >= w_eff) begin
            col_count_next = '0;
            if (row_inc >= {1'b0, h_eff}) begin
                row_count_next = '0;
                bank_next      = '0;
            end else begin
                row_count_next = row_inc[ROW_W-1:0];
                bank_next      = (bank_cur == MW'(WINDOW_SIDE - 1)) ? '0 : bank_cur + MW'(1);
            end
        end else begin
            col_count_next = col_inc[CW-1:0];
            row_count_next = row_cur;
            bank_next      = bank_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            bank_reg      <= '0;
        end else if (s_accept) begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            bank_reg      <= bank_next;
        end
    end

    // One line store bank per window row. Every item reads all banks at its
    // column and writes its own bank there; the read data of its own bank is
    // replaced by the new sample in stage 1.
    logic [DEPTH_W-1:0] ram_rdata [WINDOW_SIDE];

    for (genvar b = 0; b < WINDOW_SIDE; b++) begin : g_bank
        dwmf_ram #(
            .WIDTH (DEPTH_W),
            .DEPTH (MAX_WIDTH)
        ) u_line_store (
            .aclk    (aclk),
            .wr_en   (s_accept && (bank_cur == MW'(b))),
            .wr_addr (col_cur),
            .wr_data (sample_w),
            .rd_en   (s_accept),
            .rd_addr (col_cur),
            .rd_data (ram_rdata[b])
        );
    end

    // ------------------------------------------------------------------
    // Stage 1: the new column of the window is the line store read data
    // with the current row's entry taken from the incoming sample.
    // ------------------------------------------------------------------
    logic [DEPTH_W-1:0] s1_sample_reg;
    logic [MW-1:0]      s1_bank_reg;
    logic               s1_produce_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [DEPTH_W-1:0] col_vec [WINDOW_SIDE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_sample_reg  <= sample_w;
            s1_bank_reg    <= bank_cur;
            s1_produce_reg <= produce;
            s1_col_reg     <= center_col;
            s1_row_reg     <= center_row;
        end
    end

    always_comb begin
        for (int b = 0; b < WINDOW_SIDE; b++) begin
            col_vec[b] = (s1_bank_reg == MW'(b)) ? s1_sample_reg : ram_rdata[b];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the window registers. Every item shifts its column in; only
    // items with a full window around an interior center become valid here.
    // Columns arrive in consecutive order within a row, so the shift holds
    // exactly the window ending at the current pixel.
    // ------------------------------------------------------------------
    logic [DEPTH_W-1:0] win_reg [WINDOW_SIDE][WINDOW_SIDE];
    logic [COL_W-1:0]   s2_col_reg;
    logic [ROW_W-1:0]   s2_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            s2_valid_reg <= s1_valid_reg && s1_produce_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_xfer) begin
            for (int c = 0; c < WINDOW_SIDE - 1; c++) begin
                for (int b = 0; b < WINDOW_SIDE; b++) begin
                    win_reg[c][b] <= win_reg[c+1][b];
                end
            end
            for (int b = 0; b < WINDOW_SIDE; b++) begin
                win_reg[WINDOW_SIDE-1][b] <= col_vec[b];
            end
            s2_col_reg <= s1_col_reg;
            s2_row_reg <= s1_row_reg;
        end
    end

    // Median by rank: each element counts the elements ordered before it,
    // with ties broken by position, so exactly one element has the middle
    // rank. The window is good only if no element is zero (invalid).
    logic [DEPTH_W-1:0] elem [N];
    logic [N-1:0]       below [N];
    logic [N-1:0]       is_med;
    logic               all_ok;
    logic [DEPTH_W-1:0] median_sel;

    always_comb begin
        for (int c = 0; c < WINDOW_SIDE; c++) begin
            for (int b = 0; b < WINDOW_SIDE; b++) begin
                elem[c*WINDOW_SIDE + b] = win_reg[c][b];
            end
        end
    end

    always_comb begin
        all_ok     = 1'b1;
        median_sel = '0;
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                below[i][j] = (elem[j] < elem[i]) || ((elem[j] == elem[i]) && (j < i));
            end
            is_med[i] = (RKW'($countones(below[i])) == RKW'(MED_RANK));
            if (is_med[i]) begin
                median_sel = median_sel | elem[i];
            end
            if (elem[i] == '0) begin
                all_ok = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && s2_valid_reg) begin
            m_data_reg.center_col   <= s2_col_reg;
            m_data_reg.center_row   <= s2_row_reg;
            m_data_reg.median_depth <= all_ok ? median_sel : '0;
            m_data_reg.window_ok    <= all_ok;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_bank_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bank_reg <= MW'(WINDOW_SIDE - 1))
        else $error("line store bank index out of range");

    a_frame_start_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.frame_start |=>
            (col_count_reg == CW'(1)) && (row_count_reg == '0) && (bank_reg == '0))
        else $error("frame start did not restart the position counters");

    a_ok_median_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.window_ok |-> m_data_reg.median_depth != '0)
        else $error("good window produced a zero median");

    a_bad_median_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.window_ok |-> m_data_reg.median_depth == '0)
        else $error("bad window produced a nonzero median");

    a_center_row_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> s2_row_reg >= ROW_W'(MID))
        else $error("result for a border row");

endmodule
